/* rtl/hkrd_pkg.sv */
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types and constants for the boot keyboard report differ.
// ----------------------------------------------------------------------------
package hkrd_pkg;

   localparam int SLOT_MAX  = 6;
   localparam int KEY_SLOTS = 6;
   localparam int MOD_BITS  = 8;
   localparam int NUM_EVENTS = MOD_BITS + 2 * SLOT_MAX;
   localparam int EV_IDX_W  = $clog2(NUM_EVENTS);
   localparam int SLOT_IDX_W = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;

   localparam logic [7:0] ROLLOVER_CODE = 8'h01;
   localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;

   localparam logic [EV_IDX_W-1:0] EV_RELEASE_BASE = EV_IDX_W'(MOD_BITS);
   localparam logic [EV_IDX_W-1:0] EV_PRESS_BASE   = EV_IDX_W'(MOD_BITS + SLOT_MAX);

   // alt, ctrl, shift, meta; left before right
   localparam logic [2:0] MOD_ORDER [MOD_BITS] =
      '{3'd2, 3'd6, 3'd0, 3'd4, 3'd1, 3'd5, 3'd3, 3'd7};

   typedef struct packed {
      logic       transfer_ok;
      logic [7:0] modifier_bits;
      logic [7:0] slot_0;
      logic [7:0] slot_1;
      logic [7:0] slot_2;
      logic [7:0] slot_3;
      logic [7:0] slot_4;
      logic [7:0] slot_5;
   } req_type;

   typedef struct packed {
      logic [7:0] usage_code;
      logic       is_press;
      logic       last_event;
   } rsp_type;

   typedef logic [SLOT_MAX-1:0][7:0] slots_type;

   typedef struct packed {
      logic [NUM_EVENTS-1:0] mask;
      logic [MOD_BITS-1:0]   mods_now;
      slots_type             old_slots;
      slots_type             new_slots;
   } job_type;

endpackage

/* rtl/hkrd_front.sv */
// ----------------------------------------------------------------------------
// hkrd_front
// Holds the previous report and turns each new report into a change mask.
// ----------------------------------------------------------------------------
module hkrd_front
   import hkrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    job_push,
   output job_type job_data
);

   logic [MOD_BITS-1:0] prev_mods_ff, prev_mods_in;
   slots_type           prev_slots_ff, prev_slots_in;

   slots_type           raw_slots;
   slots_type           new_slots;
   logic [MOD_BITS-1:0] new_mods;
   logic                rollover;
   logic [NUM_EVENTS-1:0] mask;
   logic                hit;

   always_comb begin
      raw_slots = {req_data.slot_5, req_data.slot_4, req_data.slot_3,
                   req_data.slot_2, req_data.slot_1, req_data.slot_0};
      rollover = 1'b0;
      for (int i = 0; i < SLOT_MAX; i++) begin
         if (i < KEY_SLOTS && raw_slots[i] == ROLLOVER_CODE) begin
            rollover = 1'b1;
         end
      end
      for (int i = 0; i < SLOT_MAX; i++) begin
         new_slots[i] = (i < KEY_SLOTS && !rollover) ? raw_slots[i] : 8'h00;
      end
      new_mods = rollover ? '0 : req_data.modifier_bits;

      mask = '0;
      for (int k = 0; k < MOD_BITS; k++) begin
         mask[k] = new_mods[MOD_ORDER[k]] != prev_mods_ff[MOD_ORDER[k]];
      end
      for (int i = 0; i < SLOT_MAX; i++) begin
         hit = 1'b0;
         for (int j = 0; j < SLOT_MAX; j++) begin
            if (new_slots[j] == prev_slots_ff[i]) begin
               hit = 1'b1;
            end
         end
         mask[MOD_BITS + i] = (prev_slots_ff[i] != 8'h00) && !hit;
      end
      for (int i = 0; i < SLOT_MAX; i++) begin
         hit = 1'b0;
         for (int j = 0; j < SLOT_MAX; j++) begin
            if (prev_slots_ff[j] == new_slots[i]) begin
               hit = 1'b1;
            end
         end
         mask[MOD_BITS + SLOT_MAX + i] = (new_slots[i] != 8'h00) && !hit;
      end
   end

   assign job_data.mask      = mask;
   assign job_data.mods_now  = new_mods;
   assign job_data.old_slots = prev_slots_ff;
   assign job_data.new_slots = new_slots;
   assign job_push = req_valid && req_data.transfer_ok && (mask != '0);

   always_comb begin
      prev_mods_in  = prev_mods_ff;
      prev_slots_in = prev_slots_ff;
      if (req_valid && req_data.transfer_ok) begin
         prev_mods_in  = new_mods;
         prev_slots_in = new_slots;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mods_ff  <= '0;
         prev_slots_ff <= '0;
      end else begin
         prev_mods_ff  <= prev_mods_in;
         prev_slots_ff <= prev_slots_in;
      end
   end

endmodule

/* rtl/hkrd_queue.sv */
// ----------------------------------------------------------------------------
// hkrd_queue
// Two-entry job queue between the classifier and the event sequencer.
// ----------------------------------------------------------------------------
module hkrd_queue
   import hkrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output job_type rd_data,
   output logic    empty
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/hkrd_back.sv */
// ----------------------------------------------------------------------------
// hkrd_back
// Walks a job's change mask; one key event per cycle while pop keeps up.
// ----------------------------------------------------------------------------
module hkrd_back
   import hkrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_data,
   output logic    job_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   job_type               cur_ff, cur_in;
   logic                  busy_ff, busy_in;
   rsp_type               out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;

   logic [EV_IDX_W-1:0]   idx;
   logic [EV_IDX_W-1:0]   rel_off;
   logic [EV_IDX_W-1:0]   prs_off;
   logic [NUM_EVENTS-1:0] rest;
   logic                  advance;
   rsp_type               ev;
   logic [2:0]            bit_sel;

   always_comb begin
      idx = '0;
      for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
         if (cur_ff.mask[i]) begin
            idx = EV_IDX_W'(i);
         end
      end
      rest = cur_ff.mask & ~(NUM_EVENTS'(1) << idx);
      rel_off = idx - EV_RELEASE_BASE;
      prs_off = idx - EV_PRESS_BASE;
      bit_sel = MOD_ORDER[idx[2:0]];

      ev.last_event = rest == '0;
      if (idx < EV_RELEASE_BASE) begin
         ev.usage_code = MOD_USAGE_BASE | {5'd0, bit_sel};
         ev.is_press   = cur_ff.mods_now[bit_sel];
      end else if (idx < EV_PRESS_BASE) begin
         ev.usage_code = cur_ff.old_slots[rel_off[SLOT_IDX_W-1:0]];
         ev.is_press   = 1'b0;
      end else begin
         ev.usage_code = cur_ff.new_slots[prs_off[SLOT_IDX_W-1:0]];
         ev.is_press   = 1'b1;
      end
   end

   assign advance  = busy_ff && (!out_valid_ff || pop);
   assign job_pop  = !busy_ff && !job_empty;
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_in       = ev;
         out_valid_in = 1'b1;
         cur_in.mask  = rest;
         busy_in      = rest != '0;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
      if (job_pop) begin
         cur_in  = job_data;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/hid_keyboard_report_differ_core.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ_core
// Turns boot keyboard reports into a stream of key press and release events.
// ----------------------------------------------------------------------------
// requests enter through push/full: one boot report with its transfer flag
// a failed transfer is taken and dropped, the stored report is kept
// the classifier compares against the stored report in the cycle of the push
// and writes a change mask into a two-entry job queue
// events leave through empty/pop, oldest first, one per cycle: modifier
// edges, then releases, then presses; last_event marks a report's final event
// a report's first event passes the queue, job register and output register
// the sequencer loads a report's job, then walks its mask; the queue
// keeps taking requests while the sequencer works
// a report with no change gives no events and uses no queue entry
// when pop stays low the output register holds, the sequencer waits and
// full rises once the queue holds two jobs
// reset clears the stored report to all keys up and empties the queue
// ----------------------------------------------------------------------------
module hid_keyboard_report_differ_core
   import hkrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    job_push;
   job_type job_wr;
   logic    job_pop;
   logic    job_empty;
   job_type job_rd;
   logic    accept;

   assign accept = push && !full;

   hkrd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(accept),
      .req_data (req_data),
      .job_push (job_push),
      .job_data (job_wr)
   );

   hkrd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_push),
      .wr_data(job_wr),
      .full   (full),
      .rd_en  (job_pop),
      .rd_data(job_rd),
      .empty  (job_empty)
   );

   hkrd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_empty(job_empty),
      .job_data (job_rd),
      .job_pop  (job_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
